// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; the including module must provide a signal named clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while rst is high.
`define MTC_ASSERT(lbl, rst, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that also holds during reset.
`define MTC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== sv/mtc_pkg.sv =====
// Shared constants and types for the multizone thermostat controller.
// No dependencies; the files that use it refer to it by scoped names.
package mtc_pkg;

   localparam int ZONES      = 4;
   localparam int TEMP_SCALE = 10;
   localparam int ZONE_W     = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int MASK_W     = 8;
   localparam int TEMP_W     = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TEMP_W-1:0] TEMP_INVALID = 16'hFFFF;
   localparam logic [1:0] QUAL_INIT = 2'd0;
   localparam logic [1:0] QUAL_BAD  = 2'd2;

   // request type codes on the input channel
   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_READING  = 2'd1;
   localparam logic [1:0] REQ_SETPOINT = 2'd2;
   localparam logic [1:0] REQ_SWITCH   = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_WAIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OPER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REST        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIFF    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE       = 3'd5;

   localparam logic [7:0]  RST_SWITCH_WAIT = 8'd5;
   localparam logic [15:0] RST_MAX_OPER    = 16'd600;
   localparam logic [7:0]  RST_REST        = 8'd60;
   localparam logic [15:0] RST_MAX_DIFF    = 16'd20;
   localparam logic [15:0] RST_HYST        = 16'd5;
   localparam logic [7:0]  RST_STALE       = 8'd30;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_READING,
      KIND_SETPOINT,
      KIND_SWITCH
   } kind_type;

   // classified request as held in the queue
   typedef struct packed {
      kind_type            kind;
      logic [ZONE_W-1:0]   zone;
      logic [TEMP_W-1:0]   value;    // temperature or scaled setpoint
      logic [1:0]          quality;
      logic                switch_on;
      logic                link_up;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

endpackage

// ===== sv/mtc_ifs.sv =====
// Request and response channel interfaces for the thermostat controller.
// Depends on nothing but plain logic types.
interface mtc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [2:0] zone;
   logic [15:0] temperature;
   logic [1:0] quality;
   logic [7:0] setpoint;
   logic       switch_on;
   logic       link_up;

   modport source (output valid, req_type, zone, temperature, quality, setpoint,
                   switch_on, link_up, input ready);
   modport sink (input valid, req_type, zone, temperature, quality, setpoint,
                 switch_on, link_up, output ready);
endinterface

interface mtc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] zone_relays;
   logic       master_relay;
   logic       status_changed;

   modport source (output valid, zone_relays, master_relay, status_changed,
                   input ready);
   modport sink (input valid, zone_relays, master_relay, status_changed,
                 output ready);
endinterface

// ===== sv/mtc_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on mtc_pkg and mtc_req_if.
module mtc_front (
   input  logic                    clock,
   input  logic                    reset,
   mtc_req_if.sink                 req_chan,
   output mtc_pkg::queue_head_type q_head,
   input  logic                    q_pop
);

   mtc_pkg::entry_type queue_mem_ff [mtc_pkg::QUEUE_DEPTH];
   logic [mtc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mtc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mtc_pkg::QCNT_W-1:0] count_ff, count_in;

   mtc_pkg::entry_type entry_in;
   logic accept;
   logic in_range;
   logic push;
   logic pop;

   assign req_chan.ready = (count_ff != mtc_pkg::QCNT_W'(mtc_pkg::QUEUE_DEPTH));
   assign accept = req_chan.valid && req_chan.ready;
   assign in_range = ({1'b0, req_chan.zone} < 4'(mtc_pkg::ZONES));

   always_comb begin
      entry_in.zone      = req_chan.zone[mtc_pkg::ZONE_W-1:0];
      entry_in.value     = req_chan.temperature;
      entry_in.quality   = req_chan.quality;
      entry_in.switch_on = req_chan.switch_on;
      entry_in.link_up   = req_chan.link_up;
      case (req_chan.req_type)
         mtc_pkg::REQ_TICK:     entry_in.kind = mtc_pkg::KIND_TICK;
         mtc_pkg::REQ_READING:  entry_in.kind = mtc_pkg::KIND_READING;
         mtc_pkg::REQ_SETPOINT: begin
            entry_in.kind  = mtc_pkg::KIND_SETPOINT;
            entry_in.value = mtc_pkg::TEMP_W'(req_chan.setpoint * mtc_pkg::TEMP_SCALE);
         end
         mtc_pkg::REQ_SWITCH:   entry_in.kind = mtc_pkg::KIND_SWITCH;
         default:               entry_in.kind = mtc_pkg::KIND_TICK;
      endcase
   end

   // writes to zones that do not exist are taken and dropped here
   assign push = accept && ((entry_in.kind == mtc_pkg::KIND_TICK) || in_range);
   assign pop  = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mtc_pkg::QPTR_W'(mtc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mtc_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mtc_pkg::QPTR_W'(mtc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mtc_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + mtc_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mtc_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.entry = queue_mem_ff[rd_ptr_ff];

endmodule

// ===== sv/mtc_back.sv =====
// Back end: configuration registers, per-zone state and the zone sequencer
// that runs one zone per cycle on a tick. Depends on mtc_pkg and mtc_rsp_if.
module mtc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  mtc_pkg::queue_head_type             q_head,
   output logic                                q_pop,
   input  logic                                csr_we,
   input  logic [mtc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mtc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   mtc_rsp_if.source                           rsp_chan
);

   typedef enum logic {ST_IDLE, ST_TICK} state_type;

   localparam int Z = mtc_pkg::ZONES;
   localparam int ZW = mtc_pkg::ZONE_W;
   localparam int MW = mtc_pkg::MASK_W;

   state_type state_ff, state_in;
   logic [ZW-1:0] idx_ff, idx_in;
   logic link_ff, link_in;
   logic [MW-1:0] mask_acc_ff, mask_acc_in;
   logic master_acc_ff, master_acc_in;
   logic [MW-1:0] last_mask_ff, last_mask_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0] relays_ff, relays_in;
   logic master_ff, master_in;
   logic changed_ff, changed_in;

   logic [7:0]  swt_ff, swt_in;
   logic [15:0] mot_ff, mot_in;
   logic [7:0]  rest_lim_ff, rest_lim_in;
   logic [15:0] mtd_ff, mtd_in;
   logic [15:0] hyst_ff, hyst_in;
   logic [7:0]  stale_lim_ff, stale_lim_in;

   logic [15:0] temp_ff [Z], temp_in [Z];
   logic [1:0]  qual_ff [Z], qual_in [Z];
   logic        fresh_ff [Z], fresh_in [Z];
   logic [7:0]  stale_ff [Z], stale_in [Z];
   logic [15:0] target_ff [Z], target_in [Z];
   logic        enabled_ff [Z], enabled_in [Z];
   logic        heat_ff [Z], heat_in [Z];
   logic [7:0]  swc_ff [Z], swc_in [Z];
   logic [15:0] opc_ff [Z], opc_in [Z];
   logic [7:0]  rstc_ff [Z], rstc_in [Z];

   // current zone datapath
   logic [7:0]  st_next;
   logic        data_ok;
   logic signed [17:0] t_s, g_s, diff_s;
   logic        heat_next;
   logic [7:0]  swc_next;
   logic [15:0] opc_next;
   logic [7:0]  rstc_next;
   logic        big_diff;
   logic        demand;
   logic [MW-1:0] mask_new;

   always_comb begin
      t_s    = $signed({2'b00, temp_ff[idx_ff]});
      g_s    = $signed({2'b00, target_ff[idx_ff]});
      diff_s = g_s - t_s;
      big_diff = diff_s > $signed({2'b00, mtd_ff});

      if (fresh_ff[idx_ff]) begin
         st_next = '0;
      end else if (stale_ff[idx_ff] < stale_lim_ff) begin
         st_next = stale_ff[idx_ff] + 8'd1;
      end else begin
         st_next = stale_ff[idx_ff];
      end

      data_ok = enabled_ff[idx_ff] && link_ff &&
                (qual_ff[idx_ff] != mtc_pkg::QUAL_BAD) &&
                (qual_ff[idx_ff] != mtc_pkg::QUAL_INIT) &&
                (temp_ff[idx_ff] != mtc_pkg::TEMP_INVALID) &&
                (st_next < stale_lim_ff);

      heat_next = heat_ff[idx_ff];
      swc_next  = swc_ff[idx_ff];
      opc_next  = opc_ff[idx_ff];
      rstc_next = rstc_ff[idx_ff];
      if (!data_ok || ((t_s > g_s - $signed({2'b00, hyst_ff})) && (t_s >= g_s))) begin
         heat_next = 1'b0;
         swc_next  = '0;
         opc_next  = '0;
         rstc_next = '0;
      end else if (t_s <= g_s - $signed({2'b00, hyst_ff})) begin
         heat_next = 1'b1;
      end

      // duty cycle: switch wait, operating, rest
      demand = 1'b0;
      if (heat_next) begin
         if (swc_next < swt_ff) begin
            swc_next = swc_next + 8'd1;
         end else if (opc_next < mot_ff) begin
            opc_next = opc_next + 16'd1;
            demand   = 1'b1;
         end else if (rstc_next < rest_lim_ff) begin
            rstc_next = rstc_next + 8'd1;
            demand    = big_diff;
         end else begin
            opc_next  = '0;
            rstc_next = '0;
            demand    = big_diff;
         end
      end

      mask_new = mask_acc_ff | (MW'(heat_next) << idx_ff);
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      link_in       = link_ff;
      mask_acc_in   = mask_acc_ff;
      master_acc_in = master_acc_ff;
      last_mask_in  = last_mask_ff;
      rsp_valid_in  = rsp_valid_ff;
      relays_in     = relays_ff;
      master_in     = master_ff;
      changed_in    = changed_ff;
      swt_in        = swt_ff;
      mot_in        = mot_ff;
      rest_lim_in   = rest_lim_ff;
      mtd_in        = mtd_ff;
      hyst_in       = hyst_ff;
      stale_lim_in  = stale_lim_ff;
      temp_in       = temp_ff;
      qual_in       = qual_ff;
      fresh_in      = fresh_ff;
      stale_in      = stale_ff;
      target_in     = target_ff;
      enabled_in    = enabled_ff;
      heat_in       = heat_ff;
      swc_in        = swc_ff;
      opc_in        = opc_ff;
      rstc_in       = rstc_ff;
      q_pop         = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            mtc_pkg::CSR_SWITCH_WAIT: swt_in       = csr_wdata[7:0];
            mtc_pkg::CSR_MAX_OPER:    mot_in       = csr_wdata;
            mtc_pkg::CSR_REST:        rest_lim_in  = csr_wdata[7:0];
            mtc_pkg::CSR_MAX_DIFF:    mtd_in       = csr_wdata;
            mtc_pkg::CSR_HYST:        hyst_in      = csr_wdata;
            mtc_pkg::CSR_STALE:       stale_lim_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               case (q_head.entry.kind)
                  mtc_pkg::KIND_TICK: begin
                     // a tick starts only once the previous result has left
                     if (!rsp_valid_ff) begin
                        q_pop         = 1'b1;
                        state_in      = ST_TICK;
                        idx_in        = '0;
                        link_in       = q_head.entry.link_up;
                        mask_acc_in   = '0;
                        master_acc_in = 1'b0;
                     end
                  end
                  mtc_pkg::KIND_READING: begin
                     q_pop = 1'b1;
                     temp_in[q_head.entry.zone]  = q_head.entry.value;
                     qual_in[q_head.entry.zone]  = q_head.entry.quality;
                     fresh_in[q_head.entry.zone] = 1'b1;
                  end
                  mtc_pkg::KIND_SETPOINT: begin
                     q_pop = 1'b1;
                     target_in[q_head.entry.zone] = q_head.entry.value;
                  end
                  mtc_pkg::KIND_SWITCH: begin
                     q_pop = 1'b1;
                     enabled_in[q_head.entry.zone] = q_head.entry.switch_on;
                  end
                  default: ;
               endcase
            end
         end
         ST_TICK: begin
            fresh_in[idx_ff] = 1'b0;
            stale_in[idx_ff] = st_next;
            heat_in[idx_ff]  = heat_next;
            swc_in[idx_ff]   = swc_next;
            opc_in[idx_ff]   = opc_next;
            rstc_in[idx_ff]  = rstc_next;
            mask_acc_in      = mask_new;
            master_acc_in    = master_acc_ff | (heat_next & demand);
            if (idx_ff == ZW'(Z - 1)) begin
               relays_in    = mask_new;
               master_in    = master_acc_ff | (heat_next & demand);
               changed_in   = (mask_new != last_mask_ff);
               last_mask_in = mask_new;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + ZW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         link_ff       <= 1'b0;
         mask_acc_ff   <= '0;
         master_acc_ff <= 1'b0;
         last_mask_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         swt_ff        <= mtc_pkg::RST_SWITCH_WAIT;
         mot_ff        <= mtc_pkg::RST_MAX_OPER;
         rest_lim_ff   <= mtc_pkg::RST_REST;
         mtd_ff        <= mtc_pkg::RST_MAX_DIFF;
         hyst_ff       <= mtc_pkg::RST_HYST;
         stale_lim_ff  <= mtc_pkg::RST_STALE;
         for (int i = 0; i < Z; i++) begin
            temp_ff[i]    <= mtc_pkg::TEMP_INVALID;
            qual_ff[i]    <= mtc_pkg::QUAL_INIT;
            fresh_ff[i]   <= 1'b0;
            stale_ff[i]   <= '0;
            target_ff[i]  <= mtc_pkg::TEMP_INVALID;
            enabled_ff[i] <= 1'b0;
            heat_ff[i]    <= 1'b0;
            swc_ff[i]     <= '0;
            opc_ff[i]     <= '0;
            rstc_ff[i]    <= '0;
         end
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         link_ff       <= link_in;
         mask_acc_ff   <= mask_acc_in;
         master_acc_ff <= master_acc_in;
         last_mask_ff  <= last_mask_in;
         rsp_valid_ff  <= rsp_valid_in;
         swt_ff        <= swt_in;
         mot_ff        <= mot_in;
         rest_lim_ff   <= rest_lim_in;
         mtd_ff        <= mtd_in;
         hyst_ff       <= hyst_in;
         stale_lim_ff  <= stale_lim_in;
         temp_ff       <= temp_in;
         qual_ff       <= qual_in;
         fresh_ff      <= fresh_in;
         stale_ff      <= stale_in;
         target_ff     <= target_in;
         enabled_ff    <= enabled_in;
         heat_ff       <= heat_in;
         swc_ff        <= swc_in;
         opc_ff        <= opc_in;
         rstc_ff       <= rstc_in;
      end
      relays_ff  <= relays_in;
      master_ff  <= master_in;
      changed_ff <= changed_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.zone_relays    = relays_ff;
   assign rsp_chan.master_relay   = master_ff;
   assign rsp_chan.status_changed = changed_ff;

endmodule

// ===== sv/multizone_thermostat_controller_core.sv =====
// Multizone thermostat controller.
// Requests enter on req_chan (valid/ready). Reading, setpoint and on/off
// requests update the addressed zone and produce no response; requests for
// a zone number past the last zone are taken and ignored. A tick request
// ages every zone, recomputes its heating decision and duty cycle, and
// yields one response on rsp_chan: zone relay mask, master relay and a
// status-changed flag.
// A write request is first stored in the request queue and then applied
// to the zone state when the back end pops it. A tick response is
// registered once the sequencer has run every zone. One write request is
// taken per cycle while the queue has room. A tick holds the sequencer
// until all zones are done; the next tick waits until the response is taken.
// A two-entry request queue separates the front end from the sequencer, so
// requests keep being taken while a response waits. If the receiver stalls,
// the response holds in its output register and the next tick waits in the
// queue; once the queue is full, req_chan.ready drops.
// csr_we/csr_index/csr_wdata write configuration registers at once, no wait.
// Synchronous reset restores register defaults and clears all zone state.
// Depends on mtc_pkg, mtc_ifs, mtc_front and mtc_back.
module multizone_thermostat_controller_core (
   input  logic                              clock,
   input  logic                              reset,
   mtc_req_if.sink                           req_chan,
   mtc_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [mtc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mtc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mtc_pkg::queue_head_type q_head;
   logic q_pop;

   mtc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   mtc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== sv/mtc_checker.sv =====
// Port-level checks for the thermostat controller core, bound to the top.
// Depends on assert_macros.svh and mtc_pkg.
`include "assert_macros.svh"

module mtc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [mtc_pkg::MASK_W-1:0] rsp_relays,
   input logic                      rsp_master,
   input logic                      rsp_changed
);

   logic [mtc_pkg::MASK_W-1:0] last_seen_ff, last_seen_in;

   assign last_seen_in = (rsp_valid && rsp_ready) ? rsp_relays : last_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seen_ff <= '0;
      end else begin
         last_seen_ff <= last_seen_in;
      end
   end

   `MTC_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")
   `MTC_ASSERT(a_rsp_hold, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")
   `MTC_ASSERT(a_master_needs_zone, reset, rsp_valid && rsp_master |-> rsp_relays != '0, "master relay with no zone")
   `MTC_ASSERT(a_changed_flag, reset, rsp_valid |-> rsp_changed == (rsp_relays != last_seen_ff), "status flag mismatch")

endmodule

bind multizone_thermostat_controller_core mtc_checker u_mtc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_relays  (rsp_chan.zone_relays),
   .rsp_master  (rsp_chan.master_relay),
   .rsp_changed (rsp_chan.status_changed)
);
